// File: hdl/kvp_pkg.sv
`default_nettype none

package kvp_pkg;

  // Default size limits of a buffer
  localparam longint unsigned MAX_PACK_BYTES = 64'd16777216;
  localparam longint unsigned MAX_NODES      = 64'd65536;

  // Result queue depth between the parser and the output stage
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;

  // Status codes of the closing result
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISMATCH = 3'd1;
  localparam logic [2:0] ST_OVERRUN  = 3'd2;
  localparam logic [2:0] ST_TRAILING = 3'd3;
  localparam logic [2:0] ST_TOO_BIG  = 3'd4;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_WORD   = 3'd1,
    PH_NAME   = 3'd2,
    PH_NUL    = 3'd3,
    PH_VALUE  = 3'd4,
    PH_TAIL   = 3'd5,
    PH_DRAIN  = 3'd6
  } kvp_phase_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } kvp_in_t;

  typedef struct packed {
    logic [15:0] node_number;
    logic [23:0] node_offset;
    logic [5:0]  name_length;
    logic [3:0]  kind_code;
    logic [21:0] value_length;
    logic [15:0] bucket_hash;
    logic [2:0]  status;
    logic        final_flag;
  } kvp_out_t;

  // Raw result event from the parser, formatted by the output stage
  typedef struct packed {
    logic        is_final;
    logic [15:0] nodes;
    logic [23:0] offset;
    logic [31:0] word;
    logic [31:0] crc;
    logic [2:0]  status;
  } kvp_evt_t;

  // Up to two events pushed per beat; slot 0 fills first
  typedef struct packed {
    logic [1:0]         cnt;
    kvp_evt_t [1:0]     evt;
  } kvp_push_t;

  typedef logic [31:0] kvp_crc_tab_t [256];

  // Build the byte-wise reflected CRC-32 table at elaboration
  function automatic kvp_crc_tab_t kvp_crc_gen();
    kvp_crc_tab_t tab;
    logic [31:0]  c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      tab[i] = c;
    end
    return tab;
  endfunction

  localparam kvp_crc_tab_t CRC_TABLE = kvp_crc_gen();

endpackage

`default_nettype wire

// File: hdl/kvp_front.sv
`default_nettype none

module kvp_front import kvp_pkg::*; #(
  parameter longint unsigned MaxPackBytes = MAX_PACK_BYTES,
  parameter longint unsigned MaxNodes     = MAX_NODES
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire kvp_in_t   in_data_i,
  output kvp_push_t      push_o
);

  localparam int unsigned CntW  = $clog2(MaxPackBytes + 2);
  localparam int unsigned NodeW = $clog2(MaxNodes + 1);
  localparam logic [CntW-1:0] CntSat = CntW'(MaxPackBytes + 1);

  kvp_phase_e        phase_q, phase_d;
  logic [CntW-1:0]   byte_cnt_q, byte_cnt_d;
  logic [31:0]       size_q, size_d;
  logic [31:0]       count_q, count_d;
  logic [NodeW-1:0]  nodes_q, nodes_d;
  logic [31:0]       rem_q, rem_d;
  logic [21:0]       fcnt_q, fcnt_d;
  logic [31:0]       word_q, word_d;
  logic [31:0]       crc_q, crc_d;
  logic [23:0]       offset_q, offset_d;
  logic [2:0]        err_q, err_d;

  logic [7:0]        b;
  logic              start_node;
  logic              emit_node;
  logic [5:0]        nl;
  logic [21:0]       vl;
  logic [22:0]       need;
  logic [2:0]        st;
  kvp_evt_t          node_evt;
  kvp_evt_t          fin_evt;

  assign b = in_data_i.byte_in;

  // Parse one byte per accepted beat
  always_comb begin
    phase_d    = phase_q;
    byte_cnt_d = byte_cnt_q;
    size_d     = size_q;
    count_d    = count_q;
    nodes_d    = nodes_q;
    rem_d      = rem_q;
    fcnt_d     = fcnt_q;
    word_d     = word_q;
    crc_d      = crc_q;
    offset_d   = offset_q;
    err_d      = err_q;
    start_node = 1'b0;
    emit_node  = 1'b0;
    nl         = word_q[5:0];
    vl         = word_q[31:10];
    need       = '0;
    st         = ST_OK;
    node_evt   = '0;
    fin_evt    = '0;
    push_o     = '0;

    if (accept_i) begin
      if (byte_cnt_q != CntSat) begin
        byte_cnt_d = byte_cnt_q + 1'b1;
      end

      unique case (phase_q)
        PH_HEADER: begin
          if (!fcnt_q[2]) begin
            size_d = size_q | (32'(b) << {fcnt_q[1:0], 3'b000});
          end else begin
            count_d = count_q | (32'(b) << {fcnt_q[1:0], 3'b000});
          end
          fcnt_d = fcnt_q + 1'b1;
          if (fcnt_q[2:0] == 3'd7) begin
            if (({2'b00, size_d} + 34'd8 > 34'(MaxPackBytes)) ||
                ({1'b0, count_d} > 33'(MaxNodes))) begin
              err_d   = ST_TOO_BIG;
              phase_d = PH_DRAIN;
            end else begin
              rem_d      = size_d;
              nodes_d    = '0;
              start_node = 1'b1;
            end
          end
        end
        PH_WORD: begin
          word_d = word_q | (32'(b) << {fcnt_q[1:0], 3'b000});
          fcnt_d = fcnt_q + 1'b1;
          nl     = word_d[5:0];
          vl     = word_d[31:10];
          need   = 23'd5 + 23'(nl) + 23'(vl);
          if (fcnt_q[1:0] == 2'd3) begin
            if ({9'd0, need} > rem_q) begin
              if (err_q == ST_OK) err_d = ST_OVERRUN;
              phase_d = PH_DRAIN;
            end else begin
              rem_d = rem_q - {9'd0, need};
              crc_d = CRC_INIT;
              if (nl == 6'd0) begin
                emit_node = 1'b1;
                phase_d   = PH_NUL;
              end else begin
                fcnt_d  = 22'(nl);
                phase_d = PH_NAME;
              end
            end
          end
        end
        PH_NAME: begin
          crc_d  = (crc_q >> 8) ^ CRC_TABLE[crc_q[7:0] ^ b];
          fcnt_d = fcnt_q - 1'b1;
          if (fcnt_q == 22'd1) begin
            emit_node = 1'b1;
            phase_d   = PH_NUL;
          end
        end
        PH_NUL: begin
          if (vl == 22'd0) begin
            nodes_d    = nodes_q + 1'b1;
            start_node = 1'b1;
          end else begin
            fcnt_d  = vl;
            phase_d = PH_VALUE;
          end
        end
        PH_VALUE: begin
          fcnt_d = fcnt_q - 1'b1;
          if (fcnt_q == 22'd1) begin
            nodes_d    = nodes_q + 1'b1;
            start_node = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Open the next node, or close the data area
      if (start_node) begin
        if (33'(nodes_d) >= {1'b0, count_d}) begin
          if (rem_d != 32'd0 && err_d == ST_OK) err_d = ST_TRAILING;
          phase_d = PH_TAIL;
        end else if (rem_d < 32'd5) begin
          if (err_d == ST_OK) err_d = ST_OVERRUN;
          phase_d = PH_DRAIN;
        end else begin
          phase_d  = PH_WORD;
          fcnt_d   = '0;
          word_d   = '0;
          offset_d = 24'(byte_cnt_d);
        end
      end

      node_evt.is_final = 1'b0;
      node_evt.nodes    = 16'(nodes_q);
      node_evt.offset   = offset_d;
      node_evt.word     = word_d;
      node_evt.crc      = crc_d;
      node_evt.status   = ST_OK;

      if (err_d == ST_TOO_BIG) begin
        st = ST_TOO_BIG;
      end else if (phase_d == PH_HEADER ||
                   34'(byte_cnt_d) != {2'b00, size_d} + 34'd8) begin
        st = ST_MISMATCH;
      end else begin
        st = err_d;
      end
      fin_evt.is_final = 1'b1;
      fin_evt.nodes    = 16'(nodes_d);
      fin_evt.status   = st;

      // Queue node result first, closing result after it
      if (emit_node) begin
        push_o.evt[0] = node_evt;
        push_o.evt[1] = fin_evt;
        push_o.cnt    = in_data_i.last_byte ? 2'd2 : 2'd1;
      end else if (in_data_i.last_byte) begin
        push_o.evt[0] = fin_evt;
        push_o.cnt    = 2'd1;
      end

      // Return to the header on the final byte
      if (in_data_i.last_byte) begin
        phase_d    = PH_HEADER;
        byte_cnt_d = '0;
        size_d     = '0;
        count_d    = '0;
        nodes_d    = '0;
        rem_d      = '0;
        fcnt_d     = '0;
        word_d     = '0;
        crc_d      = CRC_INIT;
        offset_d   = '0;
        err_d      = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      byte_cnt_q <= '0;
      size_q     <= '0;
      count_q    <= '0;
      nodes_q    <= '0;
      rem_q      <= '0;
      fcnt_q     <= '0;
      word_q     <= '0;
      crc_q      <= CRC_INIT;
      offset_q   <= '0;
      err_q      <= ST_OK;
    end else begin
      phase_q    <= phase_d;
      byte_cnt_q <= byte_cnt_d;
      size_q     <= size_d;
      count_q    <= count_d;
      nodes_q    <= nodes_d;
      rem_q      <= rem_d;
      fcnt_q     <= fcnt_d;
      word_q     <= word_d;
      crc_q      <= crc_d;
      offset_q   <= offset_d;
      err_q      <= err_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/kvp_queue.sv
`default_nettype none

module kvp_queue import kvp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire kvp_push_t push_i,
  input  wire logic      pop_i,
  output logic           full_o,
  output logic           valid_o,
  output kvp_evt_t       head_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  kvp_evt_t          mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wp_q, wp_d;
  logic [PtrW-1:0]   rp_q, rp_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic [PtrW-1:0]   wp_next;
  logic              pop;

  // Keep room for two events so a full beat never overflows
  assign full_o  = cnt_q > (PtrW + 1)'(QUEUE_DEPTH - 2);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rp_q];
  assign pop     = pop_i && valid_o;
  assign wp_next = wp_q + 1'b1;

  // Advance pointers and occupancy
  always_comb begin
    wp_d  = wp_q + PtrW'(push_i.cnt);
    rp_d  = pop ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (PtrW + 1)'(push_i.cnt) - (PtrW + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wp_q] <= push_i.evt[0];
    if (push_i.cnt == 2'd2) mem_q[wp_next] <= push_i.evt[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/kvp_back.sv
`default_nettype none

module kvp_back import kvp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     evt_valid_i,
  input  wire kvp_evt_t evt_i,
  output logic          evt_pop_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output kvp_out_t      out_data_o
);

  logic        valid_q, valid_d;
  kvp_out_t    data_q, data_d;
  logic [31:0] crc_fin;

  assign crc_fin = evt_i.crc ^ CRC_INIT;

  // Load the output register when it is empty or being taken
  assign evt_pop_o = evt_valid_i && (!valid_q || !out_stall_i);

  // Format the queued event into a result beat
  always_comb begin
    data_d = data_q;
    if (evt_pop_o) begin
      data_d.node_number = evt_i.nodes;
      data_d.status      = evt_i.status;
      data_d.final_flag  = evt_i.is_final;
      if (evt_i.is_final) begin
        data_d.node_offset  = '0;
        data_d.name_length  = '0;
        data_d.kind_code    = '0;
        data_d.value_length = '0;
        data_d.bucket_hash  = '0;
      end else begin
        data_d.node_offset  = evt_i.offset;
        data_d.name_length  = evt_i.word[5:0];
        data_d.kind_code    = evt_i.word[9:6];
        data_d.value_length = evt_i.word[31:10];
        data_d.bucket_hash  = crc_fin[15:0] ^ crc_fin[31:16];
      end
    end
    valid_d = evt_pop_o ? 1'b1 : (valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// File: hdl/kv_pack_index_parser.sv
`default_nettype none

// Packed key-value buffer parser. Takes one buffer byte per beat, with
// last_byte on the final one, and returns one result per node (offset, name
// and value lengths, type, 16-bit folded CRC-32 of the name) plus a closing
// status result for the buffer. A byte is taken every cycle while the input
// is not stalled, the parser updating its counters and table-driven CRC step.
// Results pass through a four-entry queue to a registered output stage; the
// input stalls only while that queue holds more than two results, so a
// stalled output backs up the input. A node result is queued on the byte
// that ends its name (its length word if the name is empty), then registered
// in the output stage; a closing result from the same byte leaves after it.
module kv_pack_index_parser import kvp_pkg::*; #(
  parameter longint unsigned MaxPackBytes = MAX_PACK_BYTES,
  parameter longint unsigned MaxNodes     = MAX_NODES
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire kvp_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output kvp_out_t      out_data_o
);

  logic      accept;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  kvp_push_t push;
  kvp_evt_t  head;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  kvp_front #(
    .MaxPackBytes (MaxPackBytes),
    .MaxNodes     (MaxNodes)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push)
  );

  kvp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head)
  );

  kvp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (q_valid),
    .evt_i       (head),
    .evt_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
